// ===== sv/parallel_biquad_cascade_bank_assert.svh =====
// Assertion macros for the filter bank control module.
`ifndef PARALLEL_BIQUAD_CASCADE_BANK_ASSERT_SVH
`define PARALLEL_BIQUAD_CASCADE_BANK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBCB_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBCB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pbcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pbcb_pkg;
    localparam int SMPW  = 24;
    localparam int COEFW = 16;
    localparam int PRODW = SMPW + COEFW;
    localparam int ACCW  = PRODW + 3;
    localparam int FRAC  = 12;
    localparam int CNTW  = 3;
    localparam int PAW   = 6;
    localparam int DATAW = 64;

    localparam int DEF_CHANNELS = 2;
    localparam int DEF_FILTERS  = 4;
    localparam int DEF_STAGES   = 4;

    localparam logic [2:0] TAP_B0 = 3'd0;
    localparam logic [2:0] TAP_B1 = 3'd1;
    localparam logic [2:0] TAP_B2 = 3'd2;
    localparam logic [2:0] TAP_A1 = 3'd3;
    localparam logic [2:0] TAP_A2 = 3'd4;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_COUNTS = 3'd1;
    localparam logic [2:0] REG_B0     = 3'd2;
    localparam logic [2:0] REG_B1     = 3'd3;
    localparam logic [2:0] REG_B2     = 3'd4;
    localparam logic [2:0] REG_A1     = 3'd5;
    localparam logic [2:0] REG_A2     = 3'd6;

    localparam logic signed [SMPW-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SMPW-1:0] SMP_MIN = -24'sh800000;

    typedef struct packed {
        logic                   channel;
        logic signed [SMPW-1:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic                   channel_out;
        logic signed [SMPW-1:0] sample_out;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       rd;
        logic       mul;
        logic [2:0] tap;
        logic       acc;
        logic       wb;
        logic       last_stage;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic ch_ok;
        logic out_busy;
    } sts_t;
endpackage
`default_nettype wire

// ===== sv/parallel_biquad_cascade_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_stall   sample_item (channel, sample_in)
// result    out        result_valid / result_stall   result_item (channel_out, sample_out)
// config    in         APB write/read, 64-bit data   registers at byte address 8*i
// Each biquad stage runs on the single shared multiplier: one history read, five products,
// a final accumulate and a write-back.
// A new transaction is taken in the cycle after the result is loaded, even while the result
// is stalled; a stalled result holds the next one back only at its load.
// Reset clears all history valid bits at once, so no clearing pass is needed.
module parallel_biquad_cascade_bank #(
    parameter int CHANNELS = pbcb_pkg::DEF_CHANNELS,
    parameter int FILTERS  = pbcb_pkg::DEF_FILTERS,
    parameter int STAGES   = pbcb_pkg::DEF_STAGES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    input  wire pbcb_pkg::in_item_t         sample_item,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output pbcb_pkg::out_item_t             result_item,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pbcb_pkg::PAW-1:0]   paddr,
    input  wire logic [pbcb_pkg::DATAW-1:0] pwdata,
    output logic [pbcb_pkg::DATAW-1:0]      prdata,
    output logic                            pready
);
    import pbcb_pkg::*;

    localparam int FW  = (FILTERS > 1) ? $clog2(FILTERS) : 1;
    localparam int STW = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic [3:0]       enable_reg;
    logic [7:0]       counts_reg;
    logic [63:0]      b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic             wr;
    logic [2:0]       ridx;
    cmd_t             cmd;
    sts_t             sts;
    logic [FW-1:0]    f_idx;
    logic [STW-1:0]   s_idx;
    logic [CNTW-1:0]  nst;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[5:3];

    always_comb
    begin
        case (ridx)
            REG_ENABLE: prdata = {60'd0, enable_reg};
            REG_COUNTS: prdata = {56'd0, counts_reg};
            REG_B0:     prdata = b0_reg;
            REG_B1:     prdata = b1_reg;
            REG_B2:     prdata = b2_reg;
            REG_A1:     prdata = a1_reg;
            REG_A2:     prdata = a2_reg;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            counts_reg <= '0;
            b0_reg     <= '0;
            b1_reg     <= '0;
            b2_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
        end
        else if (wr)
        begin
            case (ridx)
                REG_ENABLE: enable_reg <= pwdata[3:0];
                REG_COUNTS: counts_reg <= pwdata[7:0];
                REG_B0:     b0_reg     <= pwdata;
                REG_B1:     b1_reg     <= pwdata;
                REG_B2:     b2_reg     <= pwdata;
                REG_A1:     a1_reg     <= pwdata;
                REG_A2:     a2_reg     <= pwdata;
                default:    ;
            endcase
        end
    end

    pbcb_ctrl #(
        .FILTERS (FILTERS),
        .STAGES  (STAGES),
        .FW      (FW),
        .STW     (STW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .filter_enable (enable_reg[FILTERS-1:0]),
        .stage_counts  (counts_reg),
        .sts           (sts),
        .cmd           (cmd),
        .f_idx         (f_idx),
        .s_idx         (s_idx),
        .nst           (nst)
    );

    pbcb_dp #(
        .CHANNELS (CHANNELS),
        .FILTERS  (FILTERS),
        .STAGES   (STAGES),
        .FW       (FW),
        .STW      (STW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .f_idx        (f_idx),
        .s_idx        (s_idx),
        .nst          (nst),
        .coef_b0      (b0_reg),
        .coef_b1      (b1_reg),
        .coef_b2      (b2_reg),
        .coef_a1      (a1_reg),
        .coef_a2      (a2_reg),
        .sample_item  (sample_item),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_item  (result_item),
        .sts          (sts)
    );
endmodule
`default_nettype wire

// ===== sv/pbcb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "parallel_biquad_cascade_bank_assert.svh"
module pbcb_ctrl #(
    parameter int FILTERS = 4,
    parameter int STAGES  = 4,
    parameter int FW      = 2,
    parameter int STW     = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire logic [FILTERS-1:0]   filter_enable,
    input  wire logic [7:0]           stage_counts,
    input  wire pbcb_pkg::sts_t       sts,
    output pbcb_pkg::cmd_t            cmd,
    output logic [FW-1:0]             f_idx,
    output logic [STW-1:0]            s_idx,
    output logic [pbcb_pkg::CNTW-1:0] nst
);
    import pbcb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_FSEL = 7'b0000010,
        S_RD   = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_WB   = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [FW-1:0]   f_reg, f_next;
    logic [STW-1:0]  s_reg, s_next;
    logic [2:0]      tap_reg, tap_next;
    logic [CNTW-1:0] cnt_raw;
    logic            f_last;
    logic            s_last;

    assign cnt_raw = {1'b0, stage_counts[2*f_reg +: 2]} + CNTW'(1);
    assign nst     = (cnt_raw > CNTW'(STAGES)) ? CNTW'(STAGES) : cnt_raw;
    assign f_last  = (f_reg == FW'(FILTERS - 1));
    assign s_last  = (CNTW'(s_reg) == nst - CNTW'(1));

    assign sample_stall = (state_reg != S_IDLE);
    assign f_idx        = f_reg;
    assign s_idx        = s_reg;

    always_comb
    begin
        state_next = state_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        tap_next   = tap_reg;
        cmd        = '0;
        cmd.tap    = tap_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    f_next     = '0;
                    state_next = S_FSEL;
                end
            end
            S_FSEL:
            begin
                if (!sts.ch_ok)
                begin
                    state_next = S_DONE;
                end
                else if (filter_enable[f_reg])
                begin
                    s_next     = '0;
                    state_next = S_RD;
                end
                else if (f_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    f_next = f_reg + FW'(1);
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                tap_next   = TAP_B0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                cmd.acc = (tap_reg != TAP_B0);
                if (tap_reg == TAP_A2)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    tap_next = tap_reg + 3'd1;
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.wb         = 1'b1;
                cmd.last_stage = s_last;
                if (!s_last)
                begin
                    s_next     = s_reg + STW'(1);
                    state_next = S_RD;
                end
                else if (f_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    f_next     = f_reg + FW'(1);
                    state_next = S_FSEL;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            f_reg     <= '0;
            s_reg     <= '0;
            tap_reg   <= TAP_B0;
        end
        else
        begin
            state_reg <= state_next;
            f_reg     <= f_next;
            s_reg     <= s_next;
            tap_reg   <= tap_next;
        end
    end

    `PBCB_ASSERT_SAME(a_tap_range, clk, rst_n, state_reg == S_MUL, tap_reg <= TAP_A2, "tap out of range")
    `PBCB_ASSERT_SAME(a_out_free, clk, rst_n, cmd.out_load, !sts.out_busy, "result register overwritten")
    `PBCB_ASSERT_NEXT(a_out_idle, clk, rst_n, cmd.out_load, state_reg == S_IDLE, "no return to idle")
    `PBCB_ASSERT_NEXT(a_wb_rd, clk, rst_n, cmd.wb && !cmd.last_stage, state_reg == S_RD, "stage step lost")
endmodule
`default_nettype wire

// ===== sv/pbcb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pbcb_dp #(
    parameter int CHANNELS = 2,
    parameter int FILTERS  = 4,
    parameter int STAGES   = 4,
    parameter int FW       = 2,
    parameter int STW      = 2
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pbcb_pkg::cmd_t            cmd,
    input  wire logic [FW-1:0]             f_idx,
    input  wire logic [STW-1:0]            s_idx,
    input  wire logic [pbcb_pkg::CNTW-1:0] nst,
    input  wire logic [63:0]               coef_b0,
    input  wire logic [63:0]               coef_b1,
    input  wire logic [63:0]               coef_b2,
    input  wire logic [63:0]               coef_a1,
    input  wire logic [63:0]               coef_a2,
    input  wire pbcb_pkg::in_item_t        sample_item,
    input  wire logic                      result_stall,
    output logic                           result_valid,
    output pbcb_pkg::out_item_t            result_item,
    output pbcb_pkg::sts_t                 sts
);
    import pbcb_pkg::*;

    localparam int SLOTS = CHANNELS * FILTERS;
    localparam int DEPTH = SLOTS * STAGES;
    localparam int SLW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUMW  = SMPW + $clog2(FILTERS) + 1;
    localparam int HW    = 4 * SMPW;

    logic [HW-1:0]            mem [DEPTH];
    logic [DEPTH-1:0]         valid_reg;
    logic [CNTW-1:0]          last_cnt_reg [SLOTS];
    logic [HW-1:0]            rd_reg;
    logic                     hv_reg;
    logic                     ch_reg;
    logic signed [SMPW-1:0]   x0_reg;
    logic signed [SMPW-1:0]   x_reg;
    logic signed [PRODW-1:0]  prod_reg;
    logic signed [ACCW-1:0]   acc_reg;
    logic signed [SUMW-1:0]   sum_reg;
    logic                     rv_reg;
    out_item_t                ri_reg;

    logic [SLW-1:0]           slot;
    logic [AW-1:0]            addr;
    logic signed [SMPW-1:0]   x1, x2, y1, y2;
    logic signed [SMPW-1:0]   op;
    logic signed [COEFW-1:0]  cf;
    logic signed [ACCW:0]     rnd;
    logic signed [ACCW-FRAC:0] shf;
    logic signed [SMPW-1:0]   y;
    logic signed [SMPW-1:0]   sum_sat;

    assign slot = SLW'(int'(ch_reg) * FILTERS + int'(f_idx));
    assign addr = AW'(int'(slot) * STAGES + int'(s_idx));

    assign x1 = hv_reg ? rd_reg[4*SMPW-1:3*SMPW] : '0;
    assign x2 = hv_reg ? rd_reg[3*SMPW-1:2*SMPW] : '0;
    assign y1 = hv_reg ? rd_reg[2*SMPW-1:SMPW]   : '0;
    assign y2 = hv_reg ? rd_reg[SMPW-1:0]        : '0;

    always_comb
    begin
        case (cmd.tap)
            TAP_B0:
            begin
                op = x_reg;
                cf = coef_b0[COEFW*f_idx +: COEFW];
            end
            TAP_B1:
            begin
                op = x1;
                cf = coef_b1[COEFW*f_idx +: COEFW];
            end
            TAP_B2:
            begin
                op = x2;
                cf = coef_b2[COEFW*f_idx +: COEFW];
            end
            TAP_A1:
            begin
                op = y1;
                cf = coef_a1[COEFW*f_idx +: COEFW];
            end
            TAP_A2:
            begin
                op = y2;
                cf = coef_a2[COEFW*f_idx +: COEFW];
            end
            default:
            begin
                op = '0;
                cf = '0;
            end
        endcase
    end

    assign rnd = {acc_reg[ACCW-1], acc_reg} + (ACCW+1)'(2048);
    assign shf = rnd[ACCW:FRAC];
    assign y   = (shf > (ACCW-FRAC+1)'(SMP_MAX)) ? SMP_MAX :
                 (shf < (ACCW-FRAC+1)'(SMP_MIN)) ? SMP_MIN : shf[SMPW-1:0];

    assign sum_sat = (sum_reg > SUMW'(SMP_MAX)) ? SMP_MAX :
                     (sum_reg < SUMW'(SMP_MIN)) ? SMP_MIN : sum_reg[SMPW-1:0];

    assign sts.ch_ok    = (CHANNELS > 1) || (ch_reg == 1'b0);
    assign sts.out_busy = rv_reg && result_stall;
    assign result_valid = rv_reg;
    assign result_item  = ri_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_reg <= mem[addr];
        end
        if (cmd.wb)
        begin
            mem[addr] <= {x_reg, x1, y, y1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg <= sample_item.channel;
            x0_reg <= sample_item.sample_in;
            sum_reg <= '0;
        end
        else if (cmd.wb && cmd.last_stage)
        begin
            sum_reg <= sum_reg + SUMW'(y);
        end
        if (cmd.rd)
        begin
            hv_reg  <= valid_reg[addr] && (CNTW'(s_idx) < last_cnt_reg[slot]);
            acc_reg <= '0;
            if (s_idx == '0)
            begin
                x_reg <= x0_reg;
            end
        end
        else
        begin
            if (cmd.acc)
            begin
                acc_reg <= acc_reg + ACCW'(prod_reg);
            end
            if (cmd.wb)
            begin
                x_reg <= y;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= op * cf;
        end
        if (cmd.out_load)
        begin
            ri_reg.channel_out <= ch_reg;
            ri_reg.sample_out  <= sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv_reg    <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                last_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.wb)
            begin
                valid_reg[addr] <= 1'b1;
                if (cmd.last_stage)
                begin
                    last_cnt_reg[slot] <= nst;
                end
            end
            if (cmd.out_load)
            begin
                rv_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                rv_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/parallel_biquad_cascade_bank_test.sv =====
`timescale 1ns / 1ps
module parallel_biquad_cascade_bank_test;
    import pbcb_pkg::*;

    localparam int N_CH = 2;
    localparam int N_F  = 4;
    localparam int N_ST = 4;
    localparam int HDEPTH = N_CH * N_F * N_ST;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    in_item_t sample_item;
    logic result_valid;
    logic result_stall;
    out_item_t result_item;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PAW-1:0] paddr;
    logic [DATAW-1:0] pwdata;
    logic [DATAW-1:0] prdata;
    logic pready;

    parallel_biquad_cascade_bank u_top (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_item(sample_item),
        .result_valid(result_valid), .result_stall(result_stall), .result_item(result_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [3:0]  bank_enable;
    logic [7:0]  bank_counts;
    logic [63:0] bank_coef [5];
    logic signed [23:0] x1_mem [HDEPTH];
    logic signed [23:0] x2_mem [HDEPTH];
    logic signed [23:0] y1_mem [HDEPTH];
    logic signed [23:0] y2_mem [HDEPTH];
    logic [2:0] used_stages [N_CH * N_F];

    in_item_t  pending_samples [$];
    out_item_t expected_results [$];
    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int samples_sent;
    int results_seen;
    int quiet_cycles;
    int saturated_seen;
    logic sample_taken;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [23:0] clamp24(input longint v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        if (v < -64'sd8388608)
            return -24'sh800000;
        return v[23:0];
    endfunction

    function automatic longint coef_lane(input logic [63:0] r, input int f);
        logic signed [15:0] c;
        c = r[16*f +: 16];
        return longint'(c);
    endfunction

    function automatic out_item_t filter_bank_sum(input in_item_t it);
        out_item_t res;
        longint total;
        longint x;
        longint acc;
        longint y;
        int slot;
        int h;
        int nst;
        res.channel_out = it.channel;
        total = 0;
        for (int f = 0; f < N_F; f++)
        begin
            if (bank_enable[f])
            begin
                nst = int'(bank_counts[2*f +: 2]) + 1;
                slot = int'(it.channel) * N_F + f;
                x = longint'(it.sample_in);
                for (int s = 0; s < nst; s++)
                begin
                    h = slot * N_ST + s;
                    if (s >= int'(used_stages[slot]))
                    begin
                        x1_mem[h] = '0;
                        x2_mem[h] = '0;
                        y1_mem[h] = '0;
                        y2_mem[h] = '0;
                    end
                    acc = x * coef_lane(bank_coef[0], f)
                        + longint'(x1_mem[h]) * coef_lane(bank_coef[1], f)
                        + longint'(x2_mem[h]) * coef_lane(bank_coef[2], f)
                        + longint'(y1_mem[h]) * coef_lane(bank_coef[3], f)
                        + longint'(y2_mem[h]) * coef_lane(bank_coef[4], f);
                    y = longint'(clamp24((acc + 2048) >>> 12));
                    x2_mem[h] = x1_mem[h];
                    x1_mem[h] = x[23:0];
                    y2_mem[h] = y1_mem[h];
                    y1_mem[h] = y[23:0];
                    x = y;
                end
                used_stages[slot] = nst[2:0];
                total += x;
            end
        end
        res.sample_out = clamp24(total);
        if (total > 64'sd8388607 || total < -64'sd8388608)
            saturated_seen++;
        return res;
    endfunction

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_item <= '0;
            result_stall <= 1'b0;
        end
        else
        begin
            if (!sample_valid || sample_taken)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_valid <= 1'b1;
                    sample_item <= pending_samples.pop_front();
                end
                else
                    sample_valid <= 1'b0;
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        sample_taken <= sample_valid && !sample_stall;
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (sample_valid && !sample_stall)
            begin
                expected_results.insert(expected_results.size(),
                    filter_bank_sum(sample_item));
                samples_sent <= samples_sent + 1;
            end
            if (result_valid && !result_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected transaction: channel_out %0d sample_out %0d",
                        result_item.channel_out, result_item.sample_out);
                    error_count++;
                end
                else
                begin
                    out_item_t want;
                    want = expected_results.pop_front();
                    if (want.channel_out !== result_item.channel_out)
                    begin
                        $error("channel_out: expected %0d, actual %0d",
                            want.channel_out, result_item.channel_out);
                        error_count++;
                    end
                    if (want.sample_out !== result_item.sample_out)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                            want.sample_out, result_item.sample_out);
                        error_count++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("parallel_biquad_cascade_bank_test: done, errors");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PAW'({idx, 3'b000});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_ENABLE: bank_enable = value[3:0];
            REG_COUNTS: bank_counts = value[7:0];
            REG_B0: bank_coef[0] = value;
            REG_B1: bank_coef[1] = value;
            REG_B2: bank_coef[2] = value;
            REG_A1: bank_coef[3] = value;
            REG_A2: bank_coef[4] = value;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain;
        while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] tame_coefs(input int span);
        logic [63:0] v;
        for (int f = 0; f < 4; f++)
            v[16*f +: 16] = 16'($signed($urandom_range(2 * span)) - span);
        return v;
    endfunction

    function automatic logic signed [23:0] rand_sample;
        case ($urandom_range(7))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'($signed($urandom_range(200)) - 100);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic load_config(input logic [3:0] en, input logic [7:0] cnt,
                               input logic [63:0] b0, input logic [63:0] b1,
                               input logic [63:0] b2, input logic [63:0] a1,
                               input logic [63:0] a2);
        reg_write(REG_ENABLE, {60'd0, en});
        reg_write(REG_COUNTS, {56'd0, cnt});
        reg_write(REG_B0, b0);
        reg_write(REG_B1, b1);
        reg_write(REG_B2, b2);
        reg_write(REG_A1, a1);
        reg_write(REG_A2, a2);
    endtask

    task automatic queue_random(input int count);
        in_item_t it;
        for (int i = 0; i < count; i++)
        begin
            it.channel = $urandom_range(1);
            it.sample_in = rand_sample();
            pending_samples.insert(pending_samples.size(), it);
        end
    endtask

    initial
    begin
        in_item_t it;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        samples_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        saturated_seen = 0;
        bank_enable = '0;
        bank_counts = '0;
        for (int i = 0; i < 5; i++)
            bank_coef[i] = '0;
        for (int i = 0; i < HDEPTH; i++)
        begin
            x1_mem[i] = '0;
            x2_mem[i] = '0;
            y1_mem[i] = '0;
            y2_mem[i] = '0;
        end
        for (int i = 0; i < N_CH * N_F; i++)
            used_stages[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        it.channel = 1'b0;
        it.sample_in = 24'sh7FFFFF;
        pending_samples.insert(pending_samples.size(), it);
        drain();

        load_config(4'hF, 8'h00, {4{16'sd4096}}, 64'd0, 64'd0, 64'd0, 64'd0);
        foreach (it.sample_in[b])
        begin
            it.channel = b[0];
            it.sample_in = 24'sh1 << b;
            pending_samples.insert(pending_samples.size(), it);
        end
        it.sample_in = -24'sh800000;
        pending_samples.insert(pending_samples.size(), it);
        drain();

        load_config(4'hF, 8'hFF, {4{16'h7FFF}}, {4{16'h8000}}, {4{16'h7FFF}},
            {4{16'h8000}}, {4{16'h7FFF}});
        it.channel = 1'b0;
        it.sample_in = 24'sh7FFFFF;
        pending_samples.insert(pending_samples.size(), it);
        it.channel = 1'b1;
        it.sample_in = -24'sh800000;
        pending_samples.insert(pending_samples.size(), it);
        drain();
        reg_write(REG_COUNTS, 64'h0000_0000_0000_00E4);
        pending_samples.insert(pending_samples.size(), it);
        it.channel = 1'b0;
        pending_samples.insert(pending_samples.size(), it);
        drain();

        for (int phase = 0; phase < 20; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            if (phase % 5 == 4)
                load_config(4'($urandom), 8'($urandom), rand64(), rand64(), rand64(),
                    rand64(), rand64());
            else
                load_config(4'($urandom), 8'($urandom), tame_coefs(6000), tame_coefs(3000),
                    tame_coefs(3000), tame_coefs(2000), tame_coefs(1000));
            queue_random(50);
            drain();
        end

        $display("parallel_biquad_cascade_bank_test: %0d samples sent, %0d results checked,",
            samples_sent, results_seen);
        $display("  %0d sums saturated, across 24 register settings and four idling mixes.",
            saturated_seen);
        if (error_count == 0)
            $display("parallel_biquad_cascade_bank_test: done, clean");
        else
            $display("parallel_biquad_cascade_bank_test: done, errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/pbcb_pkg.sv
sv/pbcb_ctrl.sv
sv/pbcb_dp.sv
sv/parallel_biquad_cascade_bank.sv
tb/parallel_biquad_cascade_bank_test.sv
